// ----- src/gmc_pkg.sv -----
// shared types and constants for the max-flow / min-cut block
// no dependencies; used by gmc_ctrl, gmc_dp and global_min_cut_max_flow
package gmc_pkg;

    localparam int FLOW_W = 16;
    localparam int NCFG_W = 9;
    localparam logic [NCFG_W-1:0] NCFG_RESET = 9'd256;

    // request opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_FLOW  = 2'd1;
    localparam logic [1:0] OP_CUT   = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] node_a;
        logic [7:0] node_b;
        logic [7:0] capacity;
    } req_t;

    typedef struct packed {
        logic [FLOW_W-1:0] flow_value;
        logic              found;
    } res_t;

    // which value goes out with a result
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_TOTAL,
        SRC_BEST
    } src_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_WR_AB,
        ST_WR_BA,
        ST_EK_BEGIN,
        ST_EK_COPY,
        ST_BFS_INIT,
        ST_BFS_POP,
        ST_BFS_LOAD,
        ST_BFS_SCAN,
        ST_BFS_END,
        ST_AUGB_INIT,
        ST_AUGB_PAR,
        ST_AUGB_RES,
        ST_AUGB_CMP,
        ST_AUGU_INIT,
        ST_AUGU_PAR,
        ST_AUGU_RES,
        ST_AUGU_WR1,
        ST_AUGU_WR2,
        ST_EK_DONE,
        ST_GC_INIT,
        ST_GC_NEXT,
        ST_GC_POP,
        ST_GC_LOAD,
        ST_GC_SCAN,
        ST_GC_END,
        ST_GC_KRD,
        ST_GC_KNEXT,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clr_en;
        logic latch;
        logic wr_ab;
        logic wr_ba;
        logic ek_begin;
        logic ek_from_gc;
        logic copy_en;
        logic bfs_init;
        logic pop_rd;
        logic pop_load;
        logic scan_en;
        logic scan_eval;
        logic augb_init;
        logic par_rd;
        logic aug_res;
        logic augb_cmp;
        logic augu_init;
        logic augu_wr1;
        logic augu_wr2;
        logic gc_init;
        logic gc_skip;
        logic gc_open;
        logic gc_pop_rd;
        logic gc_pop_load;
        logic gc_scan_en;
        logic gc_scan_eval;
        logic gc_k_init;
        logic gc_k_rd;
        logic gc_k_next;
        logic emit;
        src_t emit_src;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       clr_last;
        logic [1:0] req_op;
        logic       edge_ok;
        logic       mf_ok;
        logic       copy_last;
        logic       bfs_empty;
        logic       scan_last;
        logic       hit_t;
        logic       at_src;
        logic       gc_end;
        logic       gc_done_s;
        logic       gc_empty;
        logic       gc_k_end;
    } sts_t;

endpackage

// ----- src/gmc_ctrl.sv -----
// sequencer for edge writes, edmonds-karp and the component-wise min cut
// depends on gmc_pkg; drives gmc_dp through cmd_t and reads sts_t
module gmc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  gmc_pkg::sts_t sts,
    output logic          busy,
    output gmc_pkg::cmd_t cmd
);

    gmc_pkg::state_t state_reg, state_next;
    logic            mode_reg, mode_next;
    gmc_pkg::src_t   src_reg, src_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gmc_pkg::ST_CLEAR;
            mode_reg  <= 1'b0;
            src_reg   <= gmc_pkg::SRC_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            src_reg   <= src_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        src_next       = src_reg;
        cmd            = '0;
        cmd.emit_src   = src_reg;
        cmd.ek_from_gc = mode_reg;
        busy           = 1'b1;
        case (state_reg)
            gmc_pkg::ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                    state_next = gmc_pkg::ST_IDLE;
            end
            gmc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = gmc_pkg::ST_DECODE;
                end
            end
            gmc_pkg::ST_DECODE:
            begin
                case (sts.req_op)
                    gmc_pkg::OP_WRITE:
                        state_next = sts.edge_ok ? gmc_pkg::ST_WR_AB : gmc_pkg::ST_IDLE;
                    gmc_pkg::OP_FLOW:
                    begin
                        mode_next = 1'b0;
                        if (sts.mf_ok)
                            state_next = gmc_pkg::ST_EK_BEGIN;
                        else
                        begin
                            src_next   = gmc_pkg::SRC_ZERO;
                            state_next = gmc_pkg::ST_EMIT;
                        end
                    end
                    gmc_pkg::OP_CUT:
                    begin
                        mode_next  = 1'b1;
                        state_next = gmc_pkg::ST_GC_INIT;
                    end
                    default:
                        state_next = gmc_pkg::ST_IDLE;
                endcase
            end
            gmc_pkg::ST_WR_AB:
            begin
                cmd.wr_ab  = 1'b1;
                state_next = gmc_pkg::ST_WR_BA;
            end
            gmc_pkg::ST_WR_BA:
            begin
                cmd.wr_ba  = 1'b1;
                state_next = gmc_pkg::ST_IDLE;
            end
            gmc_pkg::ST_EK_BEGIN:
            begin
                cmd.ek_begin = 1'b1;
                state_next   = gmc_pkg::ST_EK_COPY;
            end
            gmc_pkg::ST_EK_COPY:
            begin
                cmd.copy_en = 1'b1;
                if (sts.copy_last)
                    state_next = gmc_pkg::ST_BFS_INIT;
            end
            gmc_pkg::ST_BFS_INIT:
            begin
                cmd.bfs_init = 1'b1;
                state_next   = gmc_pkg::ST_BFS_POP;
            end
            gmc_pkg::ST_BFS_POP:
            begin
                if (sts.bfs_empty)
                    state_next = gmc_pkg::ST_EK_DONE;
                else
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = gmc_pkg::ST_BFS_LOAD;
                end
            end
            gmc_pkg::ST_BFS_LOAD:
            begin
                cmd.pop_load = 1'b1;
                state_next   = gmc_pkg::ST_BFS_SCAN;
            end
            gmc_pkg::ST_BFS_SCAN:
            begin
                cmd.scan_en   = 1'b1;
                cmd.scan_eval = 1'b1;
                if (sts.hit_t)
                    state_next = gmc_pkg::ST_AUGB_INIT;
                else if (sts.scan_last)
                    state_next = gmc_pkg::ST_BFS_END;
            end
            gmc_pkg::ST_BFS_END:
            begin
                cmd.scan_eval = 1'b1;
                state_next = sts.hit_t ? gmc_pkg::ST_AUGB_INIT : gmc_pkg::ST_BFS_POP;
            end
            // bottleneck pass along the parent chain
            gmc_pkg::ST_AUGB_INIT:
            begin
                cmd.augb_init = 1'b1;
                state_next    = gmc_pkg::ST_AUGB_PAR;
            end
            gmc_pkg::ST_AUGB_PAR:
            begin
                cmd.par_rd = 1'b1;
                state_next = gmc_pkg::ST_AUGB_RES;
            end
            gmc_pkg::ST_AUGB_RES:
            begin
                cmd.aug_res = 1'b1;
                state_next  = gmc_pkg::ST_AUGB_CMP;
            end
            gmc_pkg::ST_AUGB_CMP:
            begin
                cmd.augb_cmp = 1'b1;
                state_next = sts.at_src ? gmc_pkg::ST_AUGU_INIT : gmc_pkg::ST_AUGB_PAR;
            end
            // residual update pass
            gmc_pkg::ST_AUGU_INIT:
            begin
                cmd.augu_init = 1'b1;
                state_next    = gmc_pkg::ST_AUGU_PAR;
            end
            gmc_pkg::ST_AUGU_PAR:
            begin
                cmd.par_rd = 1'b1;
                state_next = gmc_pkg::ST_AUGU_RES;
            end
            gmc_pkg::ST_AUGU_RES:
            begin
                cmd.aug_res = 1'b1;
                state_next  = gmc_pkg::ST_AUGU_WR1;
            end
            gmc_pkg::ST_AUGU_WR1:
            begin
                cmd.augu_wr1 = 1'b1;
                state_next   = gmc_pkg::ST_AUGU_WR2;
            end
            gmc_pkg::ST_AUGU_WR2:
            begin
                cmd.augu_wr2 = 1'b1;
                state_next = sts.at_src ? gmc_pkg::ST_BFS_INIT : gmc_pkg::ST_AUGU_PAR;
            end
            gmc_pkg::ST_EK_DONE:
            begin
                if (mode_reg)
                    state_next = gmc_pkg::ST_GC_KNEXT;
                else
                begin
                    src_next   = gmc_pkg::SRC_TOTAL;
                    state_next = gmc_pkg::ST_EMIT;
                end
            end
            // component walk for the min cut
            gmc_pkg::ST_GC_INIT:
            begin
                cmd.gc_init = 1'b1;
                state_next  = gmc_pkg::ST_GC_NEXT;
            end
            gmc_pkg::ST_GC_NEXT:
            begin
                if (sts.gc_end)
                begin
                    src_next   = gmc_pkg::SRC_BEST;
                    state_next = gmc_pkg::ST_EMIT;
                end
                else if (sts.gc_done_s)
                    cmd.gc_skip = 1'b1;
                else
                begin
                    cmd.gc_open = 1'b1;
                    state_next  = gmc_pkg::ST_GC_POP;
                end
            end
            gmc_pkg::ST_GC_POP:
            begin
                if (sts.gc_empty)
                begin
                    cmd.gc_k_init = 1'b1;
                    state_next    = gmc_pkg::ST_GC_KRD;
                end
                else
                begin
                    cmd.gc_pop_rd = 1'b1;
                    state_next    = gmc_pkg::ST_GC_LOAD;
                end
            end
            gmc_pkg::ST_GC_LOAD:
            begin
                cmd.gc_pop_load = 1'b1;
                state_next      = gmc_pkg::ST_GC_SCAN;
            end
            gmc_pkg::ST_GC_SCAN:
            begin
                cmd.gc_scan_en   = 1'b1;
                cmd.gc_scan_eval = 1'b1;
                if (sts.scan_last)
                    state_next = gmc_pkg::ST_GC_END;
            end
            gmc_pkg::ST_GC_END:
            begin
                cmd.gc_scan_eval = 1'b1;
                state_next       = gmc_pkg::ST_GC_POP;
            end
            gmc_pkg::ST_GC_KRD:
            begin
                if (sts.gc_k_end)
                begin
                    cmd.gc_skip = 1'b1;
                    state_next  = gmc_pkg::ST_GC_NEXT;
                end
                else
                begin
                    cmd.gc_k_rd = 1'b1;
                    state_next  = gmc_pkg::ST_EK_BEGIN;
                end
            end
            gmc_pkg::ST_GC_KNEXT:
            begin
                cmd.gc_k_next = 1'b1;
                state_next    = gmc_pkg::ST_GC_KRD;
            end
            gmc_pkg::ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = gmc_pkg::ST_IDLE;
            end
            default:
                state_next = gmc_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- src/gmc_dp.sv -----
// datapath: capacity and residual matrices, search queue, parents, counters
// depends on gmc_pkg; sequenced by gmc_ctrl
module gmc_dp #(
    parameter int MAX_NODES = 256,
    parameter int CAP_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gmc_pkg::req_t                req,
    input  logic                         cfg_we,
    input  logic [gmc_pkg::NCFG_W-1:0]   cfg_wdata,
    input  gmc_pkg::cmd_t                cmd,
    output gmc_pkg::sts_t                sts,
    output logic                         result_valid,
    output gmc_pkg::res_t                result
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int CW    = NW + 1;
    localparam int AW    = 2 * NW;
    localparam int DEPTH = 1 << AW;
    localparam int RW    = CAP_BITS + 1;
    localparam int TW    = CAP_BITS + NW + 1;

    // storage
    logic [CAP_BITS-1:0] cap_mem [DEPTH];
    logic [RW-1:0]       res_mem [DEPTH];
    logic [NW-1:0]       par_mem [MAX_NODES];
    logic [NW-1:0]       que_mem [MAX_NODES];
    logic [NW-1:0]       grp_mem [MAX_NODES];

    logic [CAP_BITS-1:0] cap_q_reg;
    logic [RW-1:0]       res_q_reg;
    logic [NW-1:0]       par_q_reg, que_q_reg, grp_q_reg;

    gmc_pkg::req_t               req_reg;
    logic [gmc_pkg::NCFG_W-1:0]  ncfg_reg;
    logic [AW-1:0]               clr_cnt_reg;
    logic [NW-1:0]               s_reg, t_reg, u_reg, i_reg, v_reg, ci_reg, cj_reg;
    logic [CW-1:0]               head_reg, tail_reg, mhead_reg, mtail_reg, k_reg, gs_reg;
    logic [RW-1:0]               b_reg;
    logic [TW-1:0]               total_reg, best_reg;
    logic                        any_reg;
    logic [MAX_NODES-1:0]        vis_reg, done_reg;
    logic                        sv_valid_reg;
    logic [NW-1:0]               sv_node_reg;
    logic                        copy_we_reg;
    logic [AW-1:0]               copy_addr_reg;
    logic                        out_valid_reg;
    gmc_pkg::res_t               out_reg;

    logic [CW-1:0]       n_act, n_last;
    logic                bfs_ev, hit_t, gc_ev;
    logic [AW-1:0]       cap_raddr, res_raddr, cap_waddr, res_waddr;
    logic                cap_we, res_we, que_we, grp_we;
    logic [CAP_BITS-1:0] cap_wdata;
    logic [RW-1:0]       res_wdata;
    logic [NW-1:0]       que_waddr, que_wdata, grp_waddr, grp_wdata, grp_raddr;
    logic [MAX_NODES-1:0] one_hot_s;

    // active node count, clamped to the array size
    assign n_act  = (32'(ncfg_reg) > MAX_NODES) ? CW'(MAX_NODES) : CW'(ncfg_reg);
    assign n_last = n_act - CW'(1);

    // scan evaluation in the cycle after the read
    assign bfs_ev = cmd.scan_eval && sv_valid_reg && !vis_reg[sv_node_reg] &&
                    (res_q_reg != '0);
    assign hit_t  = bfs_ev && (sv_node_reg == t_reg);
    assign gc_ev  = cmd.gc_scan_eval && sv_valid_reg && !done_reg[sv_node_reg] &&
                    (cap_q_reg != '0);

    assign one_hot_s = {{(MAX_NODES-1){1'b0}}, 1'b1} << s_reg;

    // status
    always_comb
    begin
        sts.clr_last  = (clr_cnt_reg == '1);
        sts.req_op    = req_reg.opcode;
        sts.edge_ok   = (32'(req_reg.node_a) < MAX_NODES) && (32'(req_reg.node_b) < MAX_NODES);
        sts.mf_ok     = (32'(req_reg.node_a) < 32'(n_act)) &&
                        (32'(req_reg.node_b) < 32'(n_act)) &&
                        (req_reg.node_a != req_reg.node_b);
        sts.copy_last = (CW'(ci_reg) == n_last) && (CW'(cj_reg) == n_last);
        sts.bfs_empty = (head_reg == tail_reg);
        sts.scan_last = (CW'(v_reg) == n_last);
        sts.hit_t     = hit_t;
        sts.at_src    = (u_reg == s_reg);
        sts.gc_end    = (gs_reg == n_act);
        sts.gc_done_s = done_reg[gs_reg[NW-1:0]];
        sts.gc_empty  = (mhead_reg == mtail_reg);
        sts.gc_k_end  = (k_reg == mtail_reg);
    end

    // memory port muxing
    always_comb
    begin
        cap_raddr = cmd.copy_en ? {ci_reg, cj_reg} : {u_reg, v_reg};
        if (cmd.aug_res)
            res_raddr = {par_q_reg, i_reg};
        else if (cmd.augu_wr1)
            res_raddr = {i_reg, u_reg};
        else
            res_raddr = {u_reg, v_reg};
        grp_raddr = cmd.gc_k_rd ? k_reg[NW-1:0] : mhead_reg[NW-1:0];

        cap_we    = cmd.clr_en || cmd.wr_ab || cmd.wr_ba;
        cap_wdata = CAP_BITS'(req_reg.capacity);
        if (cmd.clr_en)
        begin
            cap_waddr = clr_cnt_reg;
            cap_wdata = '0;
        end
        else if (cmd.wr_ab)
            cap_waddr = {NW'(req_reg.node_a), NW'(req_reg.node_b)};
        else
            cap_waddr = {NW'(req_reg.node_b), NW'(req_reg.node_a)};

        res_we = copy_we_reg || cmd.augu_wr1 || cmd.augu_wr2;
        if (copy_we_reg)
        begin
            res_waddr = copy_addr_reg;
            res_wdata = RW'(cap_q_reg);
        end
        else if (cmd.augu_wr1)
        begin
            res_waddr = {u_reg, i_reg};
            res_wdata = res_q_reg - b_reg;
        end
        else
        begin
            res_waddr = {i_reg, u_reg};
            res_wdata = res_q_reg + b_reg;
        end

        que_we    = cmd.bfs_init || (bfs_ev && !hit_t);
        que_waddr = cmd.bfs_init ? '0 : tail_reg[NW-1:0];
        que_wdata = cmd.bfs_init ? s_reg : sv_node_reg;

        grp_we    = cmd.gc_open || gc_ev;
        grp_waddr = cmd.gc_open ? '0 : mtail_reg[NW-1:0];
        grp_wdata = cmd.gc_open ? gs_reg[NW-1:0] : sv_node_reg;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cap_we)
            cap_mem[cap_waddr] <= cap_wdata;
        cap_q_reg <= cap_mem[cap_raddr];
        if (res_we)
            res_mem[res_waddr] <= res_wdata;
        res_q_reg <= res_mem[res_raddr];
        if (bfs_ev)
            par_mem[sv_node_reg] <= u_reg;
        if (cmd.par_rd)
            par_q_reg <= par_mem[i_reg];
        if (que_we)
            que_mem[que_waddr] <= que_wdata;
        que_q_reg <= que_mem[head_reg[NW-1:0]];
        if (grp_we)
            grp_mem[grp_waddr] <= grp_wdata;
        grp_q_reg <= grp_mem[grp_raddr];
    end

    // request and copy pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            req_reg <= req;
        copy_addr_reg <= {ci_reg, cj_reg};
        sv_node_reg   <= v_reg;
    end

    // control registers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncfg_reg      <= gmc_pkg::NCFG_RESET;
            clr_cnt_reg   <= '0;
            s_reg         <= '0;
            t_reg         <= '0;
            u_reg         <= '0;
            i_reg         <= '0;
            v_reg         <= '0;
            ci_reg        <= '0;
            cj_reg        <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            mhead_reg     <= '0;
            mtail_reg     <= '0;
            k_reg         <= '0;
            gs_reg        <= '0;
            b_reg         <= '0;
            total_reg     <= '0;
            best_reg      <= '0;
            any_reg       <= 1'b0;
            vis_reg       <= '0;
            done_reg      <= '0;
            sv_valid_reg  <= 1'b0;
            copy_we_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ncfg_reg <= cfg_wdata;
            if (cmd.clr_en)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);

            sv_valid_reg <= cmd.scan_en || cmd.gc_scan_en;
            copy_we_reg  <= cmd.copy_en;

            // start of one max-flow run
            if (cmd.ek_begin)
            begin
                s_reg     <= cmd.ek_from_gc ? gs_reg[NW-1:0] : NW'(req_reg.node_a);
                t_reg     <= cmd.ek_from_gc ? grp_q_reg : NW'(req_reg.node_b);
                total_reg <= '0;
                ci_reg    <= '0;
                cj_reg    <= '0;
            end
            if (cmd.copy_en)
            begin
                if (CW'(cj_reg) == n_last)
                begin
                    cj_reg <= '0;
                    ci_reg <= ci_reg + NW'(1);
                end
                else
                    cj_reg <= cj_reg + NW'(1);
            end

            // breadth-first search
            if (cmd.bfs_init)
            begin
                vis_reg  <= one_hot_s;
                head_reg <= '0;
                tail_reg <= CW'(1);
            end
            if (cmd.pop_rd)
                head_reg <= head_reg + CW'(1);
            if (cmd.pop_load)
            begin
                u_reg <= que_q_reg;
                v_reg <= '0;
            end
            if (cmd.gc_pop_load)
            begin
                u_reg <= grp_q_reg;
                v_reg <= '0;
            end
            if (cmd.scan_en || cmd.gc_scan_en)
                v_reg <= v_reg + NW'(1);
            if (bfs_ev)
            begin
                vis_reg[sv_node_reg] <= 1'b1;
                if (!hit_t)
                    tail_reg <= tail_reg + CW'(1);
            end

            // augmenting path walk
            if (cmd.augb_init)
            begin
                i_reg <= t_reg;
                b_reg <= '1;
            end
            if (cmd.aug_res)
                u_reg <= par_q_reg;
            if (cmd.augb_cmp)
            begin
                if (res_q_reg < b_reg)
                    b_reg <= res_q_reg;
                i_reg <= u_reg;
            end
            if (cmd.augu_init)
            begin
                i_reg     <= t_reg;
                total_reg <= total_reg + TW'(b_reg);
            end
            if (cmd.augu_wr2)
                i_reg <= u_reg;

            // component walk and best cut
            if (cmd.gc_init)
            begin
                gs_reg   <= '0;
                any_reg  <= 1'b0;
                best_reg <= '0;
                done_reg <= '0;
            end
            if (cmd.gc_skip)
                gs_reg <= gs_reg + CW'(1);
            if (cmd.gc_open)
            begin
                done_reg[gs_reg[NW-1:0]] <= 1'b1;
                mhead_reg <= '0;
                mtail_reg <= CW'(1);
            end
            if (cmd.gc_pop_rd)
                mhead_reg <= mhead_reg + CW'(1);
            if (gc_ev)
            begin
                done_reg[sv_node_reg] <= 1'b1;
                mtail_reg <= mtail_reg + CW'(1);
            end
            if (cmd.gc_k_init)
                k_reg <= CW'(1);
            if (cmd.gc_k_next)
            begin
                k_reg <= k_reg + CW'(1);
                if ((total_reg != '0) && (!any_reg || (total_reg < best_reg)))
                begin
                    best_reg <= total_reg;
                    any_reg  <= 1'b1;
                end
            end
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= cmd.emit;
    end

    // result payload, saturated to the port width
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.emit_src)
                gmc_pkg::SRC_TOTAL:
                begin
                    out_reg.flow_value <= (32'(total_reg) > 32'hFFFF) ?
                                          '1 : gmc_pkg::FLOW_W'(total_reg);
                    out_reg.found      <= (total_reg != '0);
                end
                gmc_pkg::SRC_BEST:
                begin
                    out_reg.flow_value <= (32'(best_reg) > 32'hFFFF) ?
                                          '1 : gmc_pkg::FLOW_W'(best_reg);
                    out_reg.found      <= any_reg;
                end
                default:
                begin
                    out_reg.flow_value <= '0;
                    out_reg.found      <= 1'b0;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- src/global_min_cut_max_flow.sv -----
// top level of the max-flow / global min-cut engine
// depends on gmc_pkg, gmc_ctrl and gmc_dp
//
// usage:
//  - requests enter on req with start; one is taken when start is high and busy low
//  - opcode write edge stores the capacity both ways and returns nothing
//  - opcode max flow returns one result; for invalid endpoints it goes from decode
//    straight to emit with a zero flow and found low
//  - opcode min cut returns the smallest nonzero pairwise flow, found low if none
//  - a max-flow run copies the capacity matrix into the residual matrix, then per
//    augmenting path runs one search, a bottleneck walk and an update walk along the
//    path; the search reads one residual matrix entry at a time
//  - a min cut runs one max flow per non-root member of every component
//  - result_valid strobes for exactly one cycle with result; the receiver cannot stall
//  - the user writes node_count via cfg_we / cfg_wdata while the block is idle, which
//    the block does not enforce; after reset busy stays high while clearing all
//    2**(2*ceil(log2(MAX_NODES))) capacity entries (65536 at the default size)
module global_min_cut_max_flow #(
    parameter int MAX_NODES = 256,
    parameter int CAP_BITS  = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  gmc_pkg::req_t              req,
    input  logic                       cfg_we,
    input  logic [gmc_pkg::NCFG_W-1:0] cfg_wdata,
    output logic                       result_valid,
    output gmc_pkg::res_t              result
);

    gmc_pkg::cmd_t cmd;
    gmc_pkg::sts_t sts;

    // sequencer
    gmc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    // datapath
    gmc_dp #(
        .MAX_NODES (MAX_NODES),
        .CAP_BITS  (CAP_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

    // a result only comes out of a busy period
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a running request");

    // the result strobe is never held high
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held");

    // an edge write gives no result strobe registered from its decode state
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.opcode == gmc_pkg::OP_WRITE)) |=> ##1 !result_valid)
        else $error("edge write produced a result");

endmodule
